>>> src/ctsc_pkg.sv
// Shared types and constants of the C token span classifier.
package ctsc_pkg;

    localparam int OUT_BITS    = 24;
    localparam int KW_COUNT    = 11;
    localparam int KW_MAX_LEN  = 7;

    typedef logic [7:0]          t_byte;
    typedef logic [1:0]          t_span_class;
    typedef logic [2:0]          t_kw_len;
    typedef logic [OUT_BITS-1:0] t_span_pos;

    localparam t_span_class CLS_KEYWORD = 2'd0;
    localparam t_span_class CLS_PREPROC = 2'd1;
    localparam t_span_class CLS_STRING  = 2'd2;

    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_HASH    = 8'h23;
    localparam t_byte CH_QUOTE   = 8'h22;
    localparam t_byte CH_LPAREN  = 8'h28;
    localparam t_byte CH_RPAREN  = 8'h29;
    localparam t_byte CH_COMMA   = 8'h2C;
    localparam t_byte CH_EQUALS  = 8'h3D;
    localparam t_byte CH_SEMI    = 8'h3B;

    // Keyword text, right-justified: first character in the highest used byte.
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        56'("int"), 56'("char"), 56'("void"), 56'("short"), 56'("return"),
        56'("switch"), 56'("case"), 56'("default"), 56'("break"),
        56'("for"), 56'("if")
    };

    localparam t_kw_len KW_LEN [KW_COUNT] = '{
        3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4, 3'd7, 3'd5, 3'd3, 3'd2
    };

    // Scanner mode, one-hot.
    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_PRE  = 5'b00010,
        MODE_STR  = 5'b00100,
        MODE_WORD = 5'b01000,
        MODE_SKIP = 5'b10000
    } t_mode;

endpackage

>>> src/c_token_span_classifier.sv
// Top level of the C token span classifier: byte scanner and span output register.
// Path: a byte held in the input register is scanned while the span register is free;
//   a span that it closes (if any) is written into the span register, which drives the output ports.
// Throughput: one byte per cycle while the span channel is not stalled; the input register and the span register
//   let a new byte enter while a finished span still waits to be taken.
// Reset (i_rst_n low, synchronous): scanner idle, offsets and sizes zero, both
//   registers empty. The keyword window is left as is; it is only read once written.
module c_token_span_classifier #(
    parameter int POS_BITS        = 24,
    parameter int MAX_KEYWORD_LEN = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_char,
    // span channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_span_start,
    output logic [23:0] o_span_length,
    output logic [1:0]  o_span_class
);

    localparam int WIN_IDX_W = $clog2(MAX_KEYWORD_LEN);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] WIN_DEPTH = POS_BITS'(MAX_KEYWORD_LEN);
    localparam int KW_MATCH_W = ctsc_pkg::KW_COUNT;

    // ---------------- input register ----------------
    logic                r_in_valid;
    ctsc_pkg::t_byte     r_byte;
    logic                r_last;

    // ---------------- scanner state ----------------
    ctsc_pkg::t_mode     r_mode, n_mode;
    logic [POS_BITS-1:0] r_char_pos, n_char_pos;
    logic [POS_BITS-1:0] r_tok_begin, n_tok_begin;
    logic [POS_BITS-1:0] r_tok_size, n_tok_size;
    logic                r_too_long, n_too_long;
    ctsc_pkg::t_byte     r_window [MAX_KEYWORD_LEN];
    ctsc_pkg::t_byte     n_window [MAX_KEYWORD_LEN];

    // ---------------- span register ----------------
    logic                    r_out_valid;
    ctsc_pkg::t_span_pos     r_span_start, r_span_length;
    ctsc_pkg::t_span_class   r_span_class;

    logic                    out_free;   // span register can take a new span
    logic                    scan_fire;  // the held byte is scanned this cycle
    logic                    emit;       // this byte closes a tagged span
    ctsc_pkg::t_span_class   emit_class;
    logic                    kw_close;   // word closes here; tag it if it is a keyword
    logic                    is_delim;
    logic                    kw_match;
    logic [KW_MATCH_W-1:0]   kw_hit;
    logic [31:0]             start_wide, length_wide;

    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_fire  = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign is_delim = (r_byte == ctsc_pkg::CH_SPACE)  || (r_byte == ctsc_pkg::CH_NEWLINE) ||
                      (r_byte == ctsc_pkg::CH_LPAREN) || (r_byte == ctsc_pkg::CH_RPAREN)  ||
                      (r_byte == ctsc_pkg::CH_COMMA)  || (r_byte == ctsc_pkg::CH_EQUALS)  ||
                      (r_byte == ctsc_pkg::CH_SEMI);

    // Next-state of the scanner for the held byte. Span fields are taken from the
    // updated begin/size, before the end-of-buffer return to reset.
    always_comb begin
        n_mode      = r_mode;
        n_tok_begin = r_tok_begin;
        n_tok_size  = r_tok_size;
        n_too_long  = r_too_long;
        n_window    = r_window;
        n_char_pos  = (r_char_pos == POS_MAX) ? r_char_pos : r_char_pos + 1'b1;
        emit        = 1'b0;
        emit_class  = ctsc_pkg::CLS_KEYWORD;
        kw_close    = 1'b0;
        case (r_mode)
            ctsc_pkg::MODE_PRE: begin
                emit_class = ctsc_pkg::CLS_PREPROC;
                if (r_byte == ctsc_pkg::CH_SPACE) begin
                    emit   = 1'b1;
                    n_mode = ctsc_pkg::MODE_IDLE;
                end else begin
                    n_tok_size = (r_tok_size == POS_MAX) ? r_tok_size : r_tok_size + 1'b1;
                    emit       = r_last;
                end
            end
            ctsc_pkg::MODE_STR: begin
                emit_class = ctsc_pkg::CLS_STRING;
                n_tok_size = (r_tok_size == POS_MAX) ? r_tok_size : r_tok_size + 1'b1;
                if (r_byte == ctsc_pkg::CH_QUOTE) begin
                    emit   = 1'b1;
                    n_mode = ctsc_pkg::MODE_SKIP;
                end else begin
                    emit = r_last;
                end
            end
            ctsc_pkg::MODE_WORD: begin
                if (is_delim) begin
                    kw_close = 1'b1;
                    n_mode   = ctsc_pkg::MODE_IDLE;
                end else begin
                    if (r_tok_size < WIN_DEPTH) begin
                        n_window[r_tok_size[WIN_IDX_W-1:0]] = r_byte;
                    end else begin
                        n_too_long = 1'b1;
                    end
                    n_tok_size = (r_tok_size == POS_MAX) ? r_tok_size : r_tok_size + 1'b1;
                    kw_close   = r_last;
                end
            end
            ctsc_pkg::MODE_SKIP: begin
                n_mode = ctsc_pkg::MODE_IDLE;
            end
            default: begin
                if ((r_byte == ctsc_pkg::CH_SPACE) || (r_byte == ctsc_pkg::CH_NEWLINE)) begin
                    n_mode = ctsc_pkg::MODE_IDLE;
                end else begin
                    n_tok_begin = r_char_pos;
                    n_tok_size  = POS_BITS'(1);
                    n_too_long  = 1'b0;
                    if (r_byte == ctsc_pkg::CH_HASH) begin
                        n_mode     = ctsc_pkg::MODE_PRE;
                        emit_class = ctsc_pkg::CLS_PREPROC;
                        emit       = r_last;
                    end else if (r_byte == ctsc_pkg::CH_QUOTE) begin
                        n_mode     = ctsc_pkg::MODE_STR;
                        emit_class = ctsc_pkg::CLS_STRING;
                        emit       = r_last;
                    end else begin
                        n_mode      = ctsc_pkg::MODE_WORD;
                        n_window[0] = r_byte;
                        kw_close    = r_last;
                    end
                end
            end
        endcase
        if (kw_close) begin
            emit       = kw_match;
            emit_class = ctsc_pkg::CLS_KEYWORD;
        end
    end

    // Eleven keyword compares in parallel on the updated window and size.
    always_comb begin
        for (int k = 0; k < ctsc_pkg::KW_COUNT; k++) begin
            kw_hit[k] = !n_too_long &&
                        (n_tok_size == POS_BITS'(ctsc_pkg::KW_LEN[k]));
            for (int j = 0; j < ctsc_pkg::KW_MAX_LEN; j++) begin
                if ((j < int'(ctsc_pkg::KW_LEN[k])) &&
                    (n_window[j] !=
                     ctsc_pkg::KW_TEXT[k][(int'(ctsc_pkg::KW_LEN[k]) - 1 - j)*8 +: 8])) begin
                    kw_hit[k] = 1'b0;
                end
            end
        end
    end
    assign kw_match = |kw_hit;

    // Spans leave on 24 bits whatever the counter width.
    assign start_wide  = 32'(n_tok_begin);
    assign length_wide = 32'(n_tok_size);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (scan_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_char_byte;
            r_last <= i_last_char;
        end
    end

    // Scanner state; the last byte of a buffer returns it to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ctsc_pkg::MODE_IDLE;
            r_char_pos  <= '0;
            r_tok_begin <= '0;
            r_tok_size  <= '0;
            r_too_long  <= 1'b0;
        end else if (scan_fire) begin
            if (r_last) begin
                r_mode      <= ctsc_pkg::MODE_IDLE;
                r_char_pos  <= '0;
                r_tok_begin <= '0;
                r_tok_size  <= '0;
                r_too_long  <= 1'b0;
            end else begin
                r_mode      <= n_mode;
                r_char_pos  <= n_char_pos;
                r_tok_begin <= n_tok_begin;
                r_tok_size  <= n_tok_size;
                r_too_long  <= n_too_long;
            end
        end
    end

    // Keyword window: no reset, entries are only compared once written.
    always_ff @(posedge i_clk) begin
        if (scan_fire) begin
            r_window <= n_window;
        end
    end

    // Span register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_fire && emit) begin
            r_span_start  <= start_wide[23:0];
            r_span_length <= length_wide[23:0];
            r_span_class  <= emit_class;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_span_start  = r_span_start;
    assign o_span_length = r_span_length;
    assign o_span_class  = r_span_class;

endmodule

>>> src/ctsc_checker.sv
// Port-level checks of the C token span classifier, bound to the top level.
module ctsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_char_byte,
    input logic        i_last_char,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_span_start,
    input logic [23:0] o_span_length,
    input logic [1:0]  o_span_class
);

    // a stalled span stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("span dropped while stalled");

    // a stalled span keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_span_start) && $stable(o_span_length) && $stable(o_span_class))
        else $error("span payload changed while stalled");

    // reset empties the span register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("span offered right after reset");

    // only the three defined classes appear
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_class == ctsc_pkg::CLS_KEYWORD) ||
                        (o_span_class == ctsc_pkg::CLS_PREPROC) ||
                        (o_span_class == ctsc_pkg::CLS_STRING))
        else $error("undefined span class");

    // a keyword span is between two and seven characters long
    a_kw_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_span_class == ctsc_pkg::CLS_KEYWORD) |->
            (o_span_length >= 24'd2) && (o_span_length <= 24'd7))
        else $error("keyword span of impossible length");

endmodule

bind c_token_span_classifier ctsc_checker u_ctsc_checker (.*);
